/* rtl/first_negative_in_window_defines.svh */
// Assertion macros shared by the first_negative_in_window RTL.
`ifndef FIRST_NEGATIVE_IN_WINDOW_DEFINES_SVH
`define FIRST_NEGATIVE_IN_WINDOW_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define FNW_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define FNW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/fnw_pkg.sv */
// Package with the shared constants of the first-negative sliding window block.
package fnw_pkg;

	// Default depth of the negative-sample queue and largest window.
	localparam int WindowMaxDef = 64;

	// Default sample width in bits.
	localparam int SampleBitsDef = 32;

	// Width of the window size register.
	localparam int CfgBits = 7;

	// Window size after reset.
	localparam logic [CfgBits-1:0] CfgReset = CfgBits'(1);

endpackage

/* rtl/first_negative_in_window.sv */
// Top level of the first-negative sliding window block.

// The block takes one signed sample beat per cycle while in_ready is high and,
// once the current array has delivered window_size samples, returns for every
// sample the oldest negative sample among the last window_size samples, or zero
// if there is none. A sample beat with last_sample set still produces its result
// and then starts a new array. Each sample passes the input and result registers,
// and a new sample is accepted every cycle while the output side keeps up; the
// throughput is set by the queue update, which keeps the head entry and the entry
// behind it in flops and reads the queue memory one entry ahead. The queue memory
// needs no clearing pass after reset: only queued entries are read. window_size
// is to be written through the cfg port only while the block is idle, which the
// block does not enforce; zero acts as one, values above WINDOW_MAX as WINDOW_MAX.
module first_negative_in_window #(
	parameter int WINDOW_MAX  = fnw_pkg::WindowMaxDef,
	parameter int SAMPLE_BITS = fnw_pkg::SampleBitsDef
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// Configuration write channel.
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [fnw_pkg::CfgBits-1:0]  cfg_window_size,
	// Sample input channel.
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                         last_sample,
	// Result output channel.
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [SAMPLE_BITS-1:0] first_negative
);

	import fnw_pkg::*;

	// Derived widths.
	localparam int IW  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;   // queue index
	localparam int KW  = $clog2(WINDOW_MAX + 1);                       // counts 0..W
	localparam int PW  = $clog2(2 * WINDOW_MAX);                       // positions
	localparam int CW0 = (PW > KW) ? PW : KW;
	localparam int CW  = (CW0 > CfgBits) ? CW0 : CfgBits;              // compare width
	localparam int EW  = PW + SAMPLE_BITS;                             // queue entry

	localparam logic [IW:0]   W_IDX = (IW + 1)'(WINDOW_MAX);
	localparam logic [PW:0]   P_MOD = (PW + 1)'(2 * WINDOW_MAX);
	localparam logic [KW-1:0] W_CNT = KW'(WINDOW_MAX);
	localparam logic [CW-1:0] W_CMP = CW'(WINDOW_MAX);

	// Configuration register.
	logic [CfgBits-1:0] window_q;

	// Input register stage.
	logic                   valid_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic                   last_s1;

	// Queue control state.
	logic [IW-1:0] head_q;
	logic [KW-1:0] count_q;
	logic [PW-1:0] pos_q;
	logic [KW-1:0] warm_q;

	// Cached head entry, entry behind it, and the entry two behind from memory.
	logic [SAMPLE_BITS-1:0] hv_q;
	logic [PW-1:0]          hp_q;
	logic [SAMPLE_BITS-1:0] nv_q;
	logic [PW-1:0]          np_q;
	logic [EW-1:0]          rd_q;

	// Queue memory: {position, value}.
	logic [EW-1:0] mem [WINDOW_MAX];

	// Result register.
	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] result_q;

	// Step logic.
	logic                   advance;
	logic [CW-1:0]          k_eff;
	logic [PW:0]            age_wide;
	logic [PW-1:0]          age;
	logic                   neg;
	logic                   pop_age;
	logic                   pop_full;
	logic [KW-1:0]          cnt1;
	logic [KW-1:0]          cnt2;
	logic [KW-1:0]          cnt_new;
	logic [IW:0]            head_inc;
	logic [IW-1:0]          head_p1;
	logic [IW-1:0]          head2;
	logic [IW:0]            slot_sum;
	logic [IW-1:0]          slot;
	logic [SAMPLE_BITS-1:0] h1v, h2v, h3v, n1v, n2v, n3v;
	logic [PW-1:0]          h1p, h2p, h3p, n1p, n2p, n3p;
	logic [KW-1:0]          warm_new;
	logic                   emit;
	logic [PW:0]            pos_inc;
	logic [PW-1:0]          pos_new;
	logic [IW-1:0]          head_new;
	logic [IW:0]            ra_sum;
	logic [IW-1:0]          ra;
	logic                   we;
	logic [EW-1:0]          wdata;

	assign cfg_ready      = 1'b1;
	assign advance        = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready       = !valid_s1 || advance;
	assign out_valid      = out_valid_q;
	assign first_negative = result_q;

	// Window size register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= CfgReset;
		end else if (cfg_valid && cfg_ready) begin
			window_q <= cfg_window_size;
		end
	end

	// Input register stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_s1 <= sample;
			last_s1   <= last_sample;
		end
	end

	// Effective window: zero acts as one, large values clamp to the queue depth.
	always_comb begin
		if (window_q == '0) begin
			k_eff = CW'(1);
		end else if (CW'(window_q) > W_CMP) begin
			k_eff = W_CMP;
		end else begin
			k_eff = CW'(window_q);
		end
	end

	// Age of the head entry, modulo twice the queue depth.
	always_comb begin
		if (pos_q >= hp_q) begin
			age_wide = (PW + 1)'(pos_q) - (PW + 1)'(hp_q);
		end else begin
			age_wide = (PW + 1)'(pos_q) + P_MOD - (PW + 1)'(hp_q);
		end
		age = age_wide[PW-1:0];
	end

	// Retire, queue and head update for the sample in the input register.
	always_comb begin
		neg     = sample_s1[SAMPLE_BITS-1];
		pop_age = (count_q != '0) && (CW'(age) >= k_eff);

		head_inc = (IW + 1)'(head_q) + (IW + 1)'(1);
		if (head_inc >= W_IDX) begin
			head_inc = head_inc - W_IDX;
		end
		head_p1 = head_inc[IW-1:0];

		// Retire an entry that has left the window.
		cnt1 = count_q - KW'(pop_age);
		h1v  = pop_age ? nv_q : hv_q;
		h1p  = pop_age ? np_q : hp_q;
		n1v  = pop_age ? rd_q[SAMPLE_BITS-1:0] : nv_q;
		n1p  = pop_age ? rd_q[EW-1:SAMPLE_BITS] : np_q;

		// Drop the oldest entry when a push finds the queue full.
		pop_full = neg && (cnt1 >= W_CNT);
		cnt2     = cnt1 - KW'(pop_full);
		h2v      = pop_full ? n1v : h1v;
		h2p      = pop_full ? n1p : h1p;
		n2v      = pop_full ? rd_q[SAMPLE_BITS-1:0] : n1v;
		n2p      = pop_full ? rd_q[EW-1:SAMPLE_BITS] : n1p;
		head2    = (pop_age || pop_full) ? head_p1 : head_q;

		// Push a negative sample behind the last queued entry.
		slot_sum = (IW + 1)'(head2) + (IW + 1)'(cnt2);
		if (slot_sum >= W_IDX) begin
			slot_sum = slot_sum - W_IDX;
		end
		slot    = slot_sum[IW-1:0];
		cnt_new = cnt2 + KW'(neg);
		h3v     = (neg && cnt2 == '0) ? sample_s1 : h2v;
		h3p     = (neg && cnt2 == '0) ? pos_q : h2p;
		n3v     = (neg && cnt2 == KW'(1)) ? sample_s1 : n2v;
		n3p     = (neg && cnt2 == KW'(1)) ? pos_q : n2p;

		we    = advance && neg;
		wdata = {pos_q, sample_s1};

		// Warmup count and result decision.
		warm_new = (warm_q < W_CNT) ? warm_q + KW'(1) : warm_q;
		emit     = advance && (CW'(warm_new) >= k_eff);

		pos_inc = (PW + 1)'(pos_q) + (PW + 1)'(1);
		if (pos_inc >= P_MOD) begin
			pos_inc = '0;
		end
		pos_new = pos_inc[PW-1:0];

		// Head after this beat; a last sample restarts the queue at zero.
		if (!advance) begin
			head_new = head_q;
		end else if (last_s1) begin
			head_new = '0;
		end else begin
			head_new = head2;
		end

		// Memory read address runs two entries ahead of the head.
		ra_sum = (IW + 1)'(head_new) + (IW + 1)'(2);
		if (ra_sum >= W_IDX) begin
			ra_sum = ra_sum - W_IDX;
		end
		if (ra_sum >= W_IDX) begin
			ra_sum = ra_sum - W_IDX;
		end
		ra = ra_sum[IW-1:0];
	end

	// Queue control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			pos_q   <= '0;
			warm_q  <= '0;
		end else if (advance) begin
			head_q <= head_new;
			if (last_s1) begin
				count_q <= '0;
				pos_q   <= '0;
				warm_q  <= '0;
			end else begin
				count_q <= cnt_new;
				pos_q   <= pos_new;
				warm_q  <= warm_new;
			end
		end
	end

	// Head and next-entry caches.
	always_ff @(posedge clk) begin
		if (advance) begin
			hv_q <= h3v;
			hp_q <= h3p;
			nv_q <= n3v;
			np_q <= n3p;
		end
	end

	// Queue memory write, and registered read with bypass of this cycle's write.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[slot] <= wdata;
		end
		if (we && slot == ra) begin
			rd_q <= wdata;
		end else begin
			rd_q <= mem[ra];
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			result_q <= (cnt_new != '0) ? h3v : '0;
		end
	end

	// Checks on the queue bookkeeping and the result range.
	`include "first_negative_in_window_defines.svh"

	`FNW_ASSERT_NOW(a_count_bound, 1'b1, count_q <= W_CNT, "queue count exceeds depth")
	`FNW_ASSERT_NOW(a_head_bound, 1'b1, (IW + 1)'(head_q) < W_IDX, "queue head out of range")
	`FNW_ASSERT_NEXT(a_last_clears, advance && last_s1,
		count_q == '0 && warm_q == '0 && pos_q == '0, "last sample did not clear state")
	`FNW_ASSERT_NOW(a_result_nonpos, out_valid,
		first_negative[SAMPLE_BITS-1] || first_negative == '0, "positive result")

endmodule

/* test/tb_top.sv */
// Self-checking testbench for the first-negative sliding window block.
module tb_top;

	localparam int WinMax = fnw_pkg::WindowMaxDef;
	localparam int SampleBits = fnw_pkg::SampleBitsDef;
	localparam int PosMod = 2 * WinMax;
	localparam int PosBits = $clog2(PosMod);
	localparam int HeadBits = $clog2(WinMax);
	localparam int RandomSamples = 1700;
	localparam int SettleCycles = 8;
	localparam int DrainLimit = 4000;
	localparam int HoldAfterResults = 150;
	localparam int HoldCycles = 200;
	localparam int ReportLimit = 10;
	localparam int DirRows = 20;

	typedef logic signed [SampleBits-1:0] sample_t;
	typedef logic [fnw_pkg::CfgBits-1:0] win_t;

	// One row of the directed table: optional window write, the beat, optional known result.
	typedef struct packed {
		logic    do_cfg;
		win_t    cfg_val;
		sample_t value;
		logic    last;
		logic    typed;
		sample_t typed_val;
	} dir_row_t;

	logic    clk;
	logic    arst_n;
	logic    cfg_valid;
	logic    cfg_ready;
	win_t    cfg_window_size;
	logic    in_valid;
	logic    in_ready;
	sample_t sample;
	logic    last_sample;
	logic    out_valid;
	logic    out_ready;
	sample_t first_negative;

	// Known result that travels with the current input beat, if the table gives one.
	logic    beat_typed;
	sample_t beat_typed_val;

	// Shadow copy of the window queue.
	sample_t             neg_vals [WinMax];
	logic [PosBits-1:0]  neg_pos [WinMax];
	logic [HeadBits-1:0] q_head = '0;
	logic [HeadBits:0]   q_count = '0;
	logic [HeadBits:0]   warm_ctr = '0;
	logic [PosBits-1:0]  pos_ctr = '0;
	win_t                win_reg = fnw_pkg::CfgReset;

	sample_t first_neg_q [$];

	bit tx_burst = 1'b0;
	bit rx_burst = 1'b0;
	int unsigned fail_count = 0;
	int unsigned results_seen = 0;
	int unsigned samples_taken = 0;
	int unsigned cfg_writes = 0;

	first_negative_in_window dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_window_size (cfg_window_size),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.sample          (sample),
		.last_sample     (last_sample),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.first_negative  (first_negative)
	);

	// Free-running clock, period 10.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Drop the oldest queued negative sample.
	function automatic void retire_oldest();
		if (q_count != 0) begin
			q_head = HeadBits'((int'(q_head) + 1) % WinMax);
			q_count = q_count - 1'b1;
		end
	endfunction

	// Advance the shadow window by one sample; returns 1 when a result is due.
	function automatic bit advance_window(input sample_t s, input logic lst, output sample_t res);
		int k;
		int age;
		int slot;
		k = (win_reg == 0) ? 1 : ((int'(win_reg) > WinMax) ? WinMax : int'(win_reg));
		// The head leaves once its age reaches the window size.
		if (q_count != 0) begin
			age = (int'(pos_ctr) + PosMod - int'(neg_pos[q_head])) % PosMod;
			if (age >= k)
				retire_oldest();
		end
		// Negative samples join the queue; a full queue loses its oldest entry.
		if (s < 0) begin
			if (int'(q_count) >= WinMax)
				retire_oldest();
			slot = (int'(q_head) + int'(q_count)) % WinMax;
			neg_vals[slot] = s;
			neg_pos[slot] = pos_ctr;
			q_count = q_count + 1'b1;
		end
		if (int'(warm_ctr) < WinMax)
			warm_ctr = warm_ctr + 1'b1;
		res = (q_count != 0) ? neg_vals[q_head] : '0;
		advance_window = (int'(warm_ctr) >= k);
		pos_ctr = PosBits'((int'(pos_ctr) + 1) % PosMod);
		// The last sample of an array starts the next one from scratch.
		if (lst) begin
			q_head = '0;
			q_count = '0;
			pos_ctr = '0;
			warm_ctr = '0;
		end
	endfunction

	// Watch all three channels at the rising edge: predict on input, check on output.
	always @(posedge clk) begin : monitor
		sample_t pred;
		sample_t want;
		bit      due;
		if (cfg_valid && cfg_ready) begin
			win_reg = cfg_window_size;
			cfg_writes++;
		end
		if (in_valid && in_ready) begin
			due = advance_window(sample, last_sample, pred);
			samples_taken++;
			if (due || beat_typed)
				first_neg_q.insert(first_neg_q.size(), beat_typed ? beat_typed_val : pred);
		end
		if (out_valid && out_ready) begin
			results_seen++;
			if (first_neg_q.size() == 0) begin
				fail_count++;
				if (fail_count <= ReportLimit)
					$display("Result %0d arrived with nothing pending: got %0d",
						results_seen, first_negative);
			end else begin
				want = first_neg_q.pop_front();
				if (first_negative !== want) begin
					fail_count++;
					if (fail_count <= ReportLimit)
						$display("Result %0d mismatch: expected %0d, got %0d",
							results_seen, want, first_negative);
				end
			end
		end
	end

	// Offer one input beat after a random gap and hold it until it is taken.
	task automatic send_sample(input sample_t s, input logic lst, input logic typed,
			input sample_t typed_val);
		int unsigned gap;
		gap = tx_burst ? 0 : $urandom_range(0, 5);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		last_sample <= lst;
		beat_typed <= typed;
		beat_typed_val <= typed_val;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Stop offering beats and let every pending result come out.
	task automatic pause_stream();
		int n;
		@(negedge clk);
		in_valid <= 1'b0;
		n = 0;
		while (first_neg_q.size() != 0 && n < DrainLimit) begin
			@(posedge clk);
			n++;
		end
		repeat (SettleCycles) @(posedge clk);
	endtask

	// Write the window size register through its own channel.
	task automatic write_window(input win_t w);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_window_size <= w;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Output side: random stalls, stall-free stretches and one long hold-off.
	initial begin : receiver
		int unsigned stall;
		int unsigned taken;
		out_ready = 1'b0;
		taken = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = rx_burst ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			taken++;
			if (taken % 64 == 0)
				rx_burst = ($urandom_range(0, 2) == 0);
			// Hold off long enough for the block to back up into its input.
			if (taken == HoldAfterResults) begin
				@(negedge clk);
				out_ready <= 1'b0;
				repeat (HoldCycles) @(negedge clk);
			end
		end
	end

	// Stimulus: reset, directed table, then random phases of window settings.
	initial begin : stimulus
		dir_row_t    rows [DirRows];
		int unsigned sent;
		int unsigned k_eff;
		int unsigned arr_len;
		int unsigned arr_pos;
		int unsigned phase_len;
		int unsigned neg_pct;
		win_t        w;
		sample_t     s;

		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_window_size = fnw_pkg::CfgReset;
		in_valid = 1'b0;
		sample = '0;
		last_sample = 1'b0;
		beat_typed = 1'b0;
		beat_typed_val = '0;

		// Window 1 after reset, then 3, then 0, 127, a mid-array change 2 to 1, and 64.
		rows = '{
			'{1'b0, 7'd0,   32'sh8000_0000, 1'b0, 1'b1, 32'sh8000_0000},
			'{1'b0, 7'd0,   32'sh7fff_ffff, 1'b0, 1'b1, 32'sd0},
			'{1'b0, 7'd0,   32'sd0,         1'b0, 1'b1, 32'sd0},
			'{1'b0, 7'd0,   -32'sd1,        1'b1, 1'b1, -32'sd1},
			'{1'b1, 7'd3,   -32'sd5,        1'b0, 1'b0, 32'sd0},
			'{1'b0, 7'd0,   32'sd7,         1'b0, 1'b0, 32'sd0},
			'{1'b0, 7'd0,   32'sd0,         1'b0, 1'b0, 32'sd0},
			'{1'b0, 7'd0,   -32'sd9,        1'b0, 1'b0, 32'sd0},
			'{1'b0, 7'd0,   32'sd3,         1'b0, 1'b0, 32'sd0},
			'{1'b0, 7'd0,   32'sd4,         1'b0, 1'b0, 32'sd0},
			'{1'b0, 7'd0,   32'sd6,         1'b1, 1'b0, 32'sd0},
			'{1'b0, 7'd0,   -32'sd2,        1'b1, 1'b0, 32'sd0},
			'{1'b1, 7'd0,   -32'sd3,        1'b0, 1'b1, -32'sd3},
			'{1'b0, 7'd0,   32'sd5,         1'b1, 1'b1, 32'sd0},
			'{1'b1, 7'd127, -32'sd7,        1'b1, 1'b0, 32'sd0},
			'{1'b1, 7'd2,   -32'sd4,        1'b0, 1'b0, 32'sd0},
			'{1'b0, 7'd0,   -32'sd6,        1'b0, 1'b0, 32'sd0},
			'{1'b1, 7'd1,   32'sd1,         1'b0, 1'b0, 32'sd0},
			'{1'b0, 7'd0,   32'sd2,         1'b1, 1'b0, 32'sd0},
			'{1'b1, 7'd64,  32'sh8000_0000, 1'b1, 1'b0, 32'sd0}
		};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed table.
		foreach (rows[i]) begin
			if (rows[i].do_cfg) begin
				pause_stream();
				write_window(rows[i].cfg_val);
			end
			send_sample(rows[i].value, rows[i].last, rows[i].typed, rows[i].typed_val);
		end

		// Random phases; an array may stay open across a window change.
		sent = 0;
		arr_len = 0;
		arr_pos = 0;
		while (sent < RandomSamples) begin
			pause_stream();
			case ($urandom_range(0, 9))
				0: w = '0;
				1: w = 7'd127;
				2: w = win_t'(WinMax);
				3: w = win_t'($urandom_range(9, WinMax - 1));
				default: w = win_t'($urandom_range(1, 8));
			endcase
			write_window(w);
			k_eff = (w == 0) ? 1 : ((int'(w) > WinMax) ? WinMax : w);
			tx_burst = ($urandom_range(0, 3) == 0);
			neg_pct = $urandom_range(0, 100);
			phase_len = 2 * k_eff + $urandom_range(10, 60);
			for (int j = 0; j < phase_len; j++) begin
				if (arr_pos == 0)
					arr_len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, k_eff)
						: $urandom_range(k_eff, 3 * k_eff + 4);
				case ($urandom_range(0, 15))
					0: s = {1'b1, {(SampleBits - 1){1'b0}}};
					1: s = {1'b0, {(SampleBits - 1){1'b1}}};
					2: s = '0;
					3: s = '1;
					default: begin
						s = sample_t'($urandom());
						s[SampleBits-1] = ($urandom_range(0, 99) < neg_pct);
					end
				endcase
				arr_pos++;
				send_sample(s, arr_pos >= arr_len, 1'b0, '0);
				if (arr_pos >= arr_len)
					arr_pos = 0;
				sent++;
			end
		end

		pause_stream();
		if (first_neg_q.size() != 0) begin
			$display("%0d expected results never arrived", first_neg_q.size());
			fail_count += first_neg_q.size();
		end
		$display("Checked %0d results from %0d sample beats across %0d window size writes.",
			results_seen, samples_taken, cfg_writes);
		$display("Covered short arrays, out-of-range window sizes, mid-array changes and a long stall.");
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Give up if the run hangs.
	initial begin : watchdog
		#3000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
